// ----- design/grouped_stdev_aggregator_top_defines.svh -----
// Assertion macros for the file that carries checks.
// GSA_ASSERT expects i_clk and i_rst_n in the enclosing scope, GSA_ASSERT_ALWAYS only i_clk.
`ifndef GROUPED_STDEV_AGGREGATOR_TOP_DEFINES_SVH
`define GROUPED_STDEV_AGGREGATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that is switched off while reset is asserted.
`define GSA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("grouped stdev aggregator check failed");
// Check that also holds across reset.
`define GSA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("grouped stdev aggregator reset check failed");
`else
`define GSA_ASSERT(label, prop)
`define GSA_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- design/gsa_pkg.sv -----
`default_nettype none
package gsa_pkg;

    // Defaults for the top-level parameters.
    localparam int GROUPS_DEF      = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed field widths on the stream ports.
    localparam int GROUP_FIELD_W  = 10;
    localparam int SAMPLE_FIELD_W = 16;
    localparam int OUT_W          = 24;
    localparam int STATUS_W       = 2;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 64;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL_L,
        S_MUL_R_START,
        S_MUL_R,
        S_DIV_START,
        S_DIV,
        S_SQRT_START,
        S_SQRT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TAKE,
        OP_UPDATE,
        OP_LATCH,
        OP_MUL_R_START,
        OP_MUL_STEP,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        logic clr_last;
        logic iter_last;
        logic is_read;
        logic short_path;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- design/gsa_ctrl.sv -----
`default_nettype none
module gsa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    input  wire gsa_pkg::t_dp_stat i_stat,
    output logic             o_s_tready,
    output gsa_pkg::t_dp_op  o_op
);

    gsa_pkg::t_state r_state;
    gsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = gsa_pkg::OP_NOP;
        o_s_tready = 1'b0;
        case (r_state)
            gsa_pkg::S_CLEAR: begin
                o_op = gsa_pkg::OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_op    = gsa_pkg::OP_TAKE;
                    n_state = gsa_pkg::S_READ;
                end
            end
            gsa_pkg::S_READ: begin
                if (i_stat.is_read) begin
                    o_op    = gsa_pkg::OP_LATCH;
                    n_state = i_stat.short_path ? gsa_pkg::S_DONE : gsa_pkg::S_MUL_L;
                end else begin
                    o_op    = gsa_pkg::OP_UPDATE;
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_MUL_L: begin
                o_op = gsa_pkg::OP_MUL_STEP;
                if (i_stat.iter_last) begin
                    n_state = gsa_pkg::S_MUL_R_START;
                end
            end
            gsa_pkg::S_MUL_R_START: begin
                o_op    = gsa_pkg::OP_MUL_R_START;
                n_state = gsa_pkg::S_MUL_R;
            end
            gsa_pkg::S_MUL_R: begin
                o_op = gsa_pkg::OP_MUL_STEP;
                if (i_stat.iter_last) begin
                    n_state = gsa_pkg::S_DIV_START;
                end
            end
            gsa_pkg::S_DIV_START: begin
                o_op    = gsa_pkg::OP_DIV_START;
                n_state = gsa_pkg::S_DIV;
            end
            gsa_pkg::S_DIV: begin
                o_op = gsa_pkg::OP_DIV_STEP;
                if (i_stat.iter_last) begin
                    n_state = gsa_pkg::S_SQRT_START;
                end
            end
            gsa_pkg::S_SQRT_START: begin
                o_op    = gsa_pkg::OP_SQRT_START;
                n_state = gsa_pkg::S_SQRT;
            end
            gsa_pkg::S_SQRT: begin
                o_op = gsa_pkg::OP_SQRT_STEP;
                if (i_stat.iter_last) begin
                    n_state = gsa_pkg::S_DONE;
                end
            end
            gsa_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = gsa_pkg::OP_LOAD_OUT;
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gsa_pkg::S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/gsa_dp.sv -----
`default_nettype none
module gsa_dp #(
    parameter int GROUPS      = gsa_pkg::GROUPS_DEF,
    parameter int SAMPLE_BITS = gsa_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = gsa_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = gsa_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire gsa_pkg::t_dp_op                i_op,
    input  wire                                 i_mode,
    input  wire  [gsa_pkg::GROUP_FIELD_W-1:0]   i_group,
    input  wire  [gsa_pkg::SAMPLE_FIELD_W-1:0]  i_sample,
    input  wire                                 i_m_tready,
    output gsa_pkg::t_dp_stat                   o_stat,
    output logic                                o_m_tvalid,
    output logic [gsa_pkg::OUT_W-1:0]           o_std_dev,
    output logic [gsa_pkg::GROUP_FIELD_W-1:0]   o_group_out,
    output logic [gsa_pkg::OUT_W-1:0]           o_sample_total,
    output logic [gsa_pkg::STATUS_W-1:0]        o_status
);

    localparam int GI_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GX_W   = 17;
    localparam int SX_W   = 24;
    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
    localparam int SQ1_W  = 2 * SAMPLE_BITS;
    localparam int SMAG_W = SUM_W - 1;
    localparam int PROD_W = SQ_W + COUNT_BITS;
    localparam int NUM_W  = PROD_W + 2 * FRAC_BITS;
    localparam int DEN_W  = 2 * COUNT_BITS;
    localparam int ROOT_W = (NUM_W + 1) / 2;
    localparam int X_W    = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int STRY_W = ROOT_W + 4;
    localparam int RX_W   = ROOT_W + gsa_pkg::OUT_W;
    localparam int ENT_W  = 1 + COUNT_BITS + SQ_W + SUM_W;
    localparam int ITER_W = $clog2(NUM_W + 1);
    localparam int SQ_LO  = SUM_W;
    localparam int CNT_LO = SUM_W + SQ_W;
    localparam int OVF_B  = SUM_W + SQ_W + COUNT_BITS;

    // Group store: {overflow mark, count, square sum, sum} per entry.
    logic [ENT_W-1:0] mem [GROUPS];
    logic [ENT_W-1:0] r_rd_data;
    logic             w_we;
    logic [GI_W-1:0]  w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [GI_W-1:0]  w_raddr;
    logic [GX_W-1:0]  w_in_group_x;

    logic [GI_W-1:0]                   r_clr_addr;
    logic                              r_mode;
    logic [gsa_pkg::GROUP_FIELD_W-1:0] r_group;
    logic [gsa_pkg::SAMPLE_FIELD_W-1:0] r_sample;

    logic [GX_W-1:0]       w_group_x;
    logic                  w_in_range;
    logic [GI_W-1:0]       w_addr;
    logic [SUM_W-1:0]      e_sum;
    logic [SQ_W-1:0]       e_sq;
    logic [COUNT_BITS-1:0] e_cnt;
    logic                  e_ovf;
    logic                  w_short;

    logic [SX_W-1:0]               w_samp_x;
    logic signed [SAMPLE_BITS-1:0] w_samp;
    logic [SUM_W-1:0]              w_sext;
    logic [SAMPLE_BITS-1:0]        w_mag;
    logic [SQ1_W-1:0]              w_sq1;
    logic [ENT_W-1:0]              w_upd;

    logic [COUNT_BITS-1:0] r_cnt;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_short;
    logic [gsa_pkg::STATUS_W-1:0]      r_res_status;
    logic [COUNT_BITS-1:0]             r_res_total;
    logic [gsa_pkg::GROUP_FIELD_W-1:0] r_res_group;

    logic [PROD_W-1:0] r_ma;
    logic [SMAG_W-1:0] r_mb;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_lhs;
    logic [ITER_W-1:0] r_iter;
    logic [SUM_W-1:0]  w_smag_full;

    logic [NUM_W-1:0]      r_num;
    logic [DEN_W-1:0]      r_den;
    logic [DEN_W:0]        r_rem;
    logic [PROD_W-1:0]     w_diff;
    logic [COUNT_BITS-1:0] w_cntm1;
    logic [DEN_W-1:0]      w_den;
    logic [DEN_W:0]        w_dtry;
    logic                  w_dge;

    logic [X_W-1:0]    r_x;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [STRY_W-1:0] w_sr;
    logic [STRY_W-1:0] w_st;
    logic              w_sge;
    logic [RX_W-1:0]   w_root_x;
    logic [gsa_pkg::OUT_W-1:0] w_std_sat;

    logic r_m_valid;

    // Item fields and the entry that was read for it.
    assign w_group_x  = GX_W'(r_group);
    assign w_in_range = (w_group_x < GX_W'(GROUPS));
    assign w_addr     = w_group_x[GI_W-1:0];
    assign w_in_group_x = GX_W'(i_group);
    assign w_raddr    = w_in_group_x[GI_W-1:0];

    assign e_sum = r_rd_data[SUM_W-1:0];
    assign e_sq  = r_rd_data[CNT_LO-1:SQ_LO];
    assign e_cnt = r_rd_data[OVF_B-1:CNT_LO];
    assign e_ovf = r_rd_data[OVF_B];
    assign w_short = !w_in_range || (e_cnt < COUNT_BITS'(2));

    // Accumulate path: the low SAMPLE_BITS of the field, sign-extended.
    assign w_samp_x = SX_W'(r_sample);
    assign w_samp   = w_samp_x[SAMPLE_BITS-1:0];
    assign w_sext   = SUM_W'(w_samp);
    assign w_mag    = w_samp[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - w_samp) : w_samp;
    assign w_sq1    = SQ1_W'(w_mag) * SQ1_W'(w_mag);

    always_comb begin
        if (e_cnt == {COUNT_BITS{1'b1}}) begin
            w_upd        = r_rd_data;
            w_upd[OVF_B] = 1'b1;
        end else begin
            w_upd = {e_ovf, e_cnt + COUNT_BITS'(1), e_sq + SQ_W'(w_sq1), e_sum + w_sext};
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = '0;
        case (i_op)
            gsa_pkg::OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            gsa_pkg::OP_UPDATE: begin
                w_we    = w_in_range;
                w_wdata = w_upd;
            end
            gsa_pkg::OP_LATCH: begin
                w_we = w_in_range;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_op == gsa_pkg::OP_TAKE) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    // Readout arithmetic.
    assign w_smag_full = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_diff      = (r_lhs > r_prod) ? (r_lhs - r_prod) : '0;
    assign w_cntm1     = r_cnt - COUNT_BITS'(1);
    assign w_den       = r_cnt * w_cntm1;
    assign w_dtry      = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign w_dge       = (w_dtry >= {1'b0, r_den});
    assign w_sr        = {r_srem, r_x[X_W-1 -: 2]};
    assign w_st        = STRY_W'({r_root, 2'b01});
    assign w_sge       = (w_sr >= w_st);
    assign w_root_x    = RX_W'(r_root);
    assign w_std_sat   = (|w_root_x[RX_W-1:gsa_pkg::OUT_W]) ? {gsa_pkg::OUT_W{1'b1}}
                                                             : w_root_x[gsa_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_op)
            gsa_pkg::OP_TAKE: begin
                r_mode   <= i_mode;
                r_group  <= i_group;
                r_sample <= i_sample;
            end
            gsa_pkg::OP_LATCH: begin
                r_cnt       <= e_cnt;
                r_sum       <= e_sum;
                r_short     <= w_short;
                r_res_group <= r_group;
                r_res_total <= w_in_range ? e_cnt : '0;
                if (w_short) begin
                    r_res_status <= gsa_pkg::ST_FEW;
                end else if (e_ovf) begin
                    r_res_status <= gsa_pkg::ST_SAT;
                end else begin
                    r_res_status <= gsa_pkg::ST_OK;
                end
                r_ma   <= PROD_W'(e_sq);
                r_mb   <= SMAG_W'(e_cnt);
                r_prod <= '0;
                r_iter <= ITER_W'(SMAG_W - 1);
            end
            gsa_pkg::OP_MUL_R_START: begin
                r_lhs  <= r_prod;
                r_ma   <= PROD_W'(w_smag_full);
                r_mb   <= SMAG_W'(w_smag_full);
                r_prod <= '0;
                r_iter <= ITER_W'(SMAG_W - 1);
            end
            gsa_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_prod <= r_prod + r_ma;
                end
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_iter <= r_iter - ITER_W'(1);
            end
            gsa_pkg::OP_DIV_START: begin
                r_num  <= NUM_W'(w_diff) << (2 * FRAC_BITS);
                r_den  <= w_den;
                r_rem  <= '0;
                r_iter <= ITER_W'(NUM_W - 1);
            end
            gsa_pkg::OP_DIV_STEP: begin
                r_rem  <= w_dge ? (w_dtry - {1'b0, r_den}) : w_dtry;
                r_num  <= {r_num[NUM_W-2:0], w_dge};
                r_iter <= r_iter - ITER_W'(1);
            end
            gsa_pkg::OP_SQRT_START: begin
                r_x    <= X_W'(r_num);
                r_srem <= '0;
                r_root <= '0;
                r_iter <= ITER_W'(ROOT_W - 1);
            end
            gsa_pkg::OP_SQRT_STEP: begin
                r_srem <= SREM_W'(w_sge ? (w_sr - w_st) : w_sr);
                r_root <= {r_root[ROOT_W-2:0], w_sge};
                r_x    <= r_x << 2;
                r_iter <= r_iter - ITER_W'(1);
            end
            gsa_pkg::OP_LOAD_OUT: begin
                o_std_dev      <= r_short ? '0 : w_std_sat;
                o_group_out    <= r_res_group;
                o_sample_total <= gsa_pkg::OUT_W'(r_res_total);
                o_status       <= r_res_status;
            end
            default: begin
                r_mode <= r_mode;
            end
        endcase
    end

    // Sweep address and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_op == gsa_pkg::OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + GI_W'(1);
            end
            if (i_op == gsa_pkg::OP_LOAD_OUT) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid        = r_m_valid;
    assign o_stat.clr_last   = (r_clr_addr == GI_W'(GROUPS - 1));
    assign o_stat.iter_last  = (r_iter == '0);
    assign o_stat.is_read    = r_mode;
    assign o_stat.short_path = w_short;
    assign o_stat.out_free   = !r_m_valid || i_m_tready;

endmodule
`default_nettype wire

// ----- design/grouped_stdev_aggregator_top.sv -----
// Grouped sample standard deviation aggregator.
// The input stream carries one word per item. tuser holds the mode: 0 adds the
// sample to its group's sum, square sum and count, 1 reads the group out and
// clears it. An accumulate word gives no result; a readout word gives one
// result word on the output stream, with the status code on tuser.
// An accumulate word is a read-modify-write of the group memory. A readout with
// two or more samples runs two shift-add products, a restoring divider and a
// square root, one bit per cycle each; the divider works on
// NUM = 2*SAMPLE_BITS + 2*COUNT_BITS - 2 + 2*FRAC_BITS bits. A readout with fewer
// than two samples skips the arithmetic. After reset the block sweeps all GROUPS
// entries of the group memory, one entry per cycle, with the input ready low;
// then all groups read as empty.
// The result sits in an output register; accumulate words keep flowing while
// it waits, and a further readout holds until the receiver has taken it.
`default_nettype none
`include "grouped_stdev_aggregator_top_defines.svh"
module grouped_stdev_aggregator_top #(
    parameter int GROUPS      = gsa_pkg::GROUPS_DEF,
    parameter int SAMPLE_BITS = gsa_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = gsa_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = gsa_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // Fields from bit 0: group_index (10), sample_value (16), zero padding.
    input  wire  [gsa_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // Field: mode (1).
    input  wire                                  i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // Fields from bit 0: std_dev (24), group_out (10), sample_total (24), zero padding.
    output logic [gsa_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // Field: status (2).
    output logic [gsa_pkg::STATUS_W-1:0]         o_m_tuser
);

    gsa_pkg::t_dp_op   w_op;
    gsa_pkg::t_dp_stat w_stat;
    logic [gsa_pkg::OUT_W-1:0]         w_std_dev;
    logic [gsa_pkg::GROUP_FIELD_W-1:0] w_group_out;
    logic [gsa_pkg::OUT_W-1:0]         w_sample_total;

    // The controller sequences memory sweep, update and the readout arithmetic.
    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_op       (w_op)
    );

    // The datapath holds the group memory, the arithmetic units and the output register.
    gsa_dp #(
        .GROUPS      (GROUPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_mode         (i_s_tuser),
        .i_group        (i_s_tdata[9:0]),
        .i_sample       (i_s_tdata[25:10]),
        .i_m_tready     (i_m_tready),
        .o_stat         (w_stat),
        .o_m_tvalid     (o_m_tvalid),
        .o_std_dev      (w_std_dev),
        .o_group_out    (w_group_out),
        .o_sample_total (w_sample_total),
        .o_status       (o_m_tuser)
    );

    assign o_m_tdata = {6'd0, w_sample_total, w_group_out, w_std_dev};

    // Each item is taken alone, so ready drops right after an accept.
    `GSA_ASSERT(a_one_at_a_time, (i_s_tvalid && o_s_tready) |=> !o_s_tready)
    // A readout of fewer than two samples always reports zero.
    `GSA_ASSERT(a_few_is_zero, (o_m_tvalid && (o_m_tuser == gsa_pkg::ST_FEW)) |-> (o_m_tdata[23:0] == 24'd0))
    // A plain result needs at least two samples behind it.
    `GSA_ASSERT(a_ok_has_two, (o_m_tvalid && (o_m_tuser == gsa_pkg::ST_OK)) |-> (o_m_tdata[57:34] >= 24'd2))
    // Reset starts the memory sweep, during which no word is taken.
    `GSA_ASSERT_ALWAYS(a_sweep_after_reset, !i_rst_n |=> !o_s_tready)

endmodule
`default_nettype wire
